// ===== hdl/psa_pkg.sv =====
// Shared constants, register map and small residue helpers for the Atkin sieve.
// No dependencies; used by psa_cfg, psa_ctrl and prime_sieve_atkin_core.
package psa_pkg;

  localparam int unsigned SIEVE_DEPTH_DEF = 4096;

  localparam int unsigned LIMIT_W   = 12;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned ROOT_W    = 7;
  localparam int unsigned SQ_W      = 13;
  localparam int unsigned FORM_N_W  = 15;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 12'd4095;
  localparam logic [REG_IDX_W-1:0] REG_SIEVE_LIMIT = 1'b0;

  localparam logic REQ_BUILD = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // quadratic form select: 4x^2+y^2, 3x^2+y^2, 3x^2-y^2
  localparam logic [1:0] FORM_A = 2'd0;
  localparam logic [1:0] FORM_B = 2'd1;
  localparam logic [1:0] FORM_C = 2'd2;

  // k^2 mod 12 from k mod 12
  function automatic logic [3:0] sq_mod12(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0, 4'd6:                 r = 4'd0;
      4'd1, 4'd5, 4'd7, 4'd11:    r = 4'd1;
      4'd2, 4'd4, 4'd8, 4'd10:    r = 4'd4;
      4'd3, 4'd9:                 r = 4'd9;
      default:                    r = 4'd0;
    endcase
    return r;
  endfunction

  // residue mod 12 of a small value (below 48)
  function automatic logic [3:0] mod12(input logic [5:0] v);
    logic [5:0] t;
    t = v;
    for (int i = 0; i < 3; i++) begin
      if (t >= 6'd12) t = t - 6'd12;
    end
    return t[3:0];
  endfunction

endpackage

// ===== hdl/psa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module psa_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/psa_cfg.sv =====
// APB register for the sieve limit and the effective limit clipped to the store.
// Depends on psa_pkg.
module psa_cfg #(
  parameter int unsigned SIEVE_DEPTH = psa_pkg::SIEVE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psa_pkg::PADDR_W-1:0] paddr,
  input  logic [psa_pkg::DATA_W-1:0]  pwdata,
  output logic [psa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [psa_pkg::LIMIT_W-1:0] limit_o
);

  logic [psa_pkg::LIMIT_W-1:0]   limit_q, limit_d;
  logic [psa_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[psa_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    limit_d = limit_q;
    if (wr_en && reg_idx == psa_pkg::REG_SIEVE_LIMIT) begin
      limit_d = pwdata[psa_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= psa_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == psa_pkg::REG_SIEVE_LIMIT) begin
      prdata = psa_pkg::DATA_W'(limit_q);
    end
  end

  // clip to the last store entry
  always_comb begin
    limit_o = limit_q;
    if (17'(limit_q) > 17'(SIEVE_DEPTH - 1)) begin
      limit_o = psa_pkg::LIMIT_W'(SIEVE_DEPTH - 1);
    end
  end

endmodule

// ===== hdl/psa_ctrl.sv =====
// Request sequencer: clear pass, Atkin form toggles, square strike and queries,
// all as accesses to the flag RAM. Depends on psa_pkg.
module psa_ctrl #(
  parameter int unsigned SIEVE_DEPTH = psa_pkg::SIEVE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(SIEVE_DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [psa_pkg::IDX_W-1:0]   query_index_i,
  output logic                        done_o,
  output logic                        is_prime_o,
  output logic                        out_of_range_o,
  input  logic [psa_pkg::LIMIT_W-1:0] limit_i,
  output logic                        ram_we_o,
  output logic [AW-1:0]               ram_waddr_o,
  output logic                        ram_wdata_o,
  output logic                        ram_re_o,
  output logic [AW-1:0]               ram_raddr_o,
  input  logic                        ram_rdata_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CLEAR  = 10'b0000000010,
    S_SEED   = 10'b0000000100,
    S_ROOT   = 10'b0000001000,
    S_FORM   = 10'b0000010000,
    S_FWRITE = 10'b0000100000,
    S_SREAD  = 10'b0001000000,
    S_SCHECK = 10'b0010000000,
    S_STRIKE = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  localparam int unsigned RW = psa_pkg::ROOT_W;
  localparam int unsigned SW = psa_pkg::SQ_W;
  localparam int unsigned NW = psa_pkg::FORM_N_W;

  state_e          state_q, state_d;
  logic            build_q, build_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            seed_q, seed_d;
  logic [RW-1:0]   r_q, r_d;
  logic [SW-1:0]   rr_q, rr_d;
  logic [RW-1:0]   form_x_q, form_x_d, form_y_q, form_y_d;
  logic [SW-1:0]   xx_q, xx_d, yy_q, yy_d;
  logic [3:0]      xm_q, xm_d, ym_q, ym_d;
  logic [1:0]      fsel_q, fsel_d;
  logic [AW-1:0]   naddr_q, naddr_d;
  logic [RW-1:0]   sn_q, sn_d;
  logic [SW-1:0]   sq_q, sq_d;
  logic [SW-1:0]   strike_position_q, strike_position_d;
  logic            done_q, done_d, qry_q, qry_d, oor_q, oor_d;

  logic [3:0]      sx, sy, n1m, n2m, n3m;
  logic [NW-1:0]   n1, n2, n3, fn;
  logic            fhit, adv, next_n;
  logic [2*RW-1:0] sn_sq;

  assign sx  = psa_pkg::sq_mod12(xm_q);
  assign sy  = psa_pkg::sq_mod12(ym_q);
  assign n1m = psa_pkg::mod12(6'({sx, 2'b00}) + 6'(sy));
  assign n2m = psa_pkg::mod12(6'({sx, 1'b0}) + 6'(sx) + 6'(sy));
  assign n3m = psa_pkg::mod12(6'({sx, 1'b0}) + 6'(sx) + 6'd12 - 6'(sy));

  assign n1 = NW'({xx_q, 2'b00}) + NW'(yy_q);
  assign n2 = NW'({xx_q, 1'b0}) + NW'(xx_q) + NW'(yy_q);
  assign n3 = NW'({xx_q, 1'b0}) + NW'(xx_q) - NW'(yy_q);

  assign sn_sq = (2*RW)'(sn_q) * (2*RW)'(sn_q);

  always_comb begin
    fn   = '0;
    fhit = 1'b0;
    case (fsel_q)
      psa_pkg::FORM_A: begin
        fn   = n1;
        fhit = n1m inside {4'd1, 4'd5};
      end
      psa_pkg::FORM_B: begin
        fn   = n2;
        fhit = n2m == 4'd7;
      end
      psa_pkg::FORM_C: begin
        fn   = n3;
        fhit = (form_x_q > form_y_q) && n3m == 4'd11;
      end
      default: begin
        fn   = '0;
        fhit = 1'b0;
      end
    endcase
    fhit = fhit && fn <= NW'(limit_i);
  end

  always_comb begin
    state_d           = state_q;
    build_d           = build_q;
    clr_d             = clr_q;
    seed_d            = seed_q;
    r_d               = r_q;
    rr_d              = rr_q;
    form_x_d          = form_x_q;
    form_y_d          = form_y_q;
    xx_d              = xx_q;
    yy_d              = yy_q;
    xm_d              = xm_q;
    ym_d              = ym_q;
    fsel_d            = fsel_q;
    naddr_d           = naddr_q;
    sn_d              = sn_q;
    sq_d              = sq_q;
    strike_position_d = strike_position_q;
    done_d            = 1'b0;
    qry_d             = qry_q;
    oor_d             = oor_q;
    ram_we_o          = 1'b0;
    ram_waddr_o       = '0;
    ram_wdata_o       = 1'b0;
    ram_re_o          = 1'b0;
    ram_raddr_o       = '0;
    adv               = 1'b0;
    next_n            = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_type_i == psa_pkg::REQ_BUILD) begin
            state_d = S_CLEAR;
            build_d = 1'b1;
            clr_d   = '0;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = AW'(query_index_i);
            done_d      = 1'b1;
            qry_d       = 1'b1;
            oor_d       = query_index_i > limit_i;
          end
        end
      end
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + 1'b1;
        if (clr_q == AW'(SIEVE_DEPTH - 1)) begin
          state_d = build_q ? S_SEED : S_IDLE;
          seed_d  = 1'b0;
        end
      end
      S_SEED: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = seed_q ? AW'(3) : AW'(2);
        ram_wdata_o = 1'b1;
        seed_d      = 1'b1;
        if (seed_q) begin
          state_d = S_ROOT;
          r_d     = '0;
          rr_d    = '0;
        end
      end
      S_ROOT: begin
        if (rr_q < SW'(limit_i)) begin
          r_d  = r_q + 1'b1;
          rr_d = rr_q + SW'({r_q, 1'b1});
        end else if (r_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d  = S_FORM;
          form_x_d = RW'(1);
          form_y_d = RW'(1);
          xx_d     = SW'(1);
          yy_d     = SW'(1);
          xm_d     = 4'd1;
          ym_d     = 4'd1;
          fsel_d   = psa_pkg::FORM_A;
        end
      end
      S_FORM: begin
        if (fhit) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = AW'(fn);
          naddr_d     = AW'(fn);
          state_d     = S_FWRITE;
        end else begin
          adv = 1'b1;
        end
      end
      S_FWRITE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = naddr_q;
        ram_wdata_o = ~ram_rdata_i;
        adv         = 1'b1;
      end
      S_SREAD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(sn_q);
        state_d     = S_SCHECK;
      end
      S_SCHECK: begin
        if (ram_rdata_i) begin
          sq_d              = sn_sq[SW-1:0];
          strike_position_d = sn_sq[SW-1:0];
          state_d           = S_STRIKE;
        end else begin
          next_n = 1'b1;
        end
      end
      S_STRIKE: begin
        if (strike_position_q <= SW'(limit_i)) begin
          ram_we_o          = 1'b1;
          ram_waddr_o       = AW'(strike_position_q);
          strike_position_d = strike_position_q + sq_q;
        end else begin
          next_n = 1'b1;
        end
      end
      S_DONE: begin
        done_d  = 1'b1;
        qry_d   = 1'b0;
        oor_d   = 1'b0;
        build_d = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // step to the next form, then the next (x, y) pair
    if (adv) begin
      state_d = S_FORM;
      case (fsel_q)
        psa_pkg::FORM_A: fsel_d = psa_pkg::FORM_B;
        psa_pkg::FORM_B: fsel_d = psa_pkg::FORM_C;
        default: begin
          fsel_d = psa_pkg::FORM_A;
          if (form_y_q != r_q) begin
            form_y_d = form_y_q + 1'b1;
            yy_d     = yy_q + SW'({form_y_q, 1'b1});
            ym_d     = (ym_q == 4'd11) ? 4'd0 : ym_q + 4'd1;
          end else if (form_x_q != r_q) begin
            form_x_d = form_x_q + 1'b1;
            xx_d     = xx_q + SW'({form_x_q, 1'b1});
            xm_d     = (xm_q == 4'd11) ? 4'd0 : xm_q + 4'd1;
            form_y_d = RW'(1);
            yy_d     = SW'(1);
            ym_d     = 4'd1;
          end else begin
            sn_d    = RW'(5);
            state_d = (r_q >= RW'(5)) ? S_SREAD : S_DONE;
          end
        end
      endcase
    end

    if (next_n) begin
      if (sn_q != r_q) begin
        sn_d    = sn_q + 1'b1;
        state_d = S_SREAD;
      end else begin
        state_d = S_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_CLEAR;
      build_q           <= 1'b0;
      clr_q             <= '0;
      seed_q            <= 1'b0;
      r_q               <= '0;
      form_x_q          <= '0;
      form_y_q          <= '0;
      fsel_q            <= psa_pkg::FORM_A;
      sn_q              <= '0;
      strike_position_q <= '0;
      done_q            <= 1'b0;
      qry_q             <= 1'b0;
      oor_q             <= 1'b0;
    end else begin
      state_q           <= state_d;
      build_q           <= build_d;
      clr_q             <= clr_d;
      seed_q            <= seed_d;
      r_q               <= r_d;
      form_x_q          <= form_x_d;
      form_y_q          <= form_y_d;
      fsel_q            <= fsel_d;
      sn_q              <= sn_d;
      strike_position_q <= strike_position_d;
      done_q            <= done_d;
      qry_q             <= qry_d;
      oor_q             <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rr_q    <= rr_d;
    xx_q    <= xx_d;
    yy_q    <= yy_d;
    xm_q    <= xm_d;
    ym_q    <= ym_d;
    naddr_q <= naddr_d;
    sq_q    <= sq_d;
  end

  assign busy           = state_q != S_IDLE;
  assign done_o         = done_q;
  assign out_of_range_o = oor_q;
  assign is_prime_o     = qry_q && !oor_q && ram_rdata_i;

  a_build_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == psa_pkg::REQ_BUILD |=> busy && !done_o)
    else $error("build item did not start the sequencer");

  a_query_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_type_i == psa_pkg::REQ_QUERY |=> done_o)
    else $error("query result missing one cycle after accept");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && ram_re_o |-> ram_waddr_o != ram_raddr_o)
    else $error("flag RAM read and write to the same entry");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !ram_we_o)
    else $error("flag RAM written while idle");

  a_oor_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_range_o |-> !is_prime_o)
    else $error("out-of-range query reported as prime");

endmodule

// ===== hdl/prime_sieve_atkin_core.sv =====
// Top level of the Atkin prime sieve: APB limit register, sequencer, flag RAM.
// Depends on psa_pkg, psa_cfg, psa_ctrl and psa_ram.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low.
//   req_type_i = 0 rebuilds the flag store up to the limit; 1 queries
//   query_index_i. Every item gives one result on is_prime_o and
//   out_of_range_o, valid for the single cycle in which done_o is high.
//   The receiver cannot stall; results must be taken when shown.
//   Queries: busy stays low, one item per cycle, and the result appears in
//   the cycle after accept, from the registered read of the flag RAM.
//   Builds: busy is high from the cycle after accept until the result.
//   A build clears all SIEVE_DEPTH entries, makes two seed writes, finds
//   R = ceil(sqrt(limit)), toggles per form and (x, y) pair where it hits (a
//   toggle reads then writes), reads each candidate 5..R and strikes the
//   multiples of its square when flagged, then gives the result.
//   Reset: the limit register returns to 4095 and a clearing pass over all
//   SIEVE_DEPTH entries zeroes the store with busy high; no result follows.
//   The user must write the sieve_limit register at byte address 0 over APB
//   only while idle; the block does not enforce it. pready is always high.
module prime_sieve_atkin_core #(
  parameter int unsigned SIEVE_DEPTH = psa_pkg::SIEVE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        req_type_i,
  input  logic [psa_pkg::IDX_W-1:0]   query_index_i,
  output logic                        done_o,
  output logic                        is_prime_o,
  output logic                        out_of_range_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psa_pkg::PADDR_W-1:0] paddr,
  input  logic [psa_pkg::DATA_W-1:0]  pwdata,
  output logic [psa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned AW = $clog2(SIEVE_DEPTH);

  logic [psa_pkg::LIMIT_W-1:0] limit;
  logic                        ram_we, ram_re, ram_wdata, ram_rdata;
  logic [AW-1:0]               ram_waddr, ram_raddr;

  psa_cfg #(
    .SIEVE_DEPTH(SIEVE_DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  psa_ctrl #(
    .SIEVE_DEPTH(SIEVE_DEPTH)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .query_index_i  (query_index_i),
    .done_o         (done_o),
    .is_prime_o     (is_prime_o),
    .out_of_range_o (out_of_range_o),
    .limit_i        (limit),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  psa_ram #(
    .WIDTH(1),
    .DEPTH(SIEVE_DEPTH)
  ) u_flags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
